### design/pcl_pkg.sv
`default_nettype none
package pcl_pkg;
  localparam int unsigned MaxCellsPerAxis = 8;
  localparam int unsigned CellCapacity    = 8;
  localparam int unsigned MaxResults      = 64;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_QUERY  = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_NEIGHBOR  = 3'd0,
    ST_NONE      = 3'd1,
    ST_INSERTED  = 3'd2,
    ST_RANGE     = 3'd3,
    ST_FULL      = 3'd4,
    ST_CLEARED   = 3'd5,
    ST_TRUNCATED = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    REG_BOX_X   = 3'd0,
    REG_BOX_Y   = 3'd1,
    REG_BOX_Z   = 3'd2,
    REG_CELLS_X = 3'd3,
    REG_CELLS_Y = 3'd4,
    REG_CELLS_Z = 3'd5,
    REG_CUTOFF  = 3'd6
  } reg_e;
endpackage
`default_nettype wire

### design/pcl_div.sv
`default_nettype none
// Restoring divider: quotient and remainder of a 20-bit numerator by a 16-bit
// divisor, one quotient bit per cycle.
module pcl_div import pcl_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [19:0] num_i,
  input  wire logic [15:0] den_i,
  output logic             done_o,
  output logic [19:0]      quo_o,
  output logic [15:0]      rem_o
);
  logic [4:0]  cnt_q, cnt_d;
  logic        run_q, run_d;
  logic [19:0] quo_q, quo_d;
  logic [16:0] rem_q, rem_d;
  logic [15:0] den_q, den_d;
  logic [17:0] trial;

  always_comb begin
    run_d = run_q;
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    trial = '0;
    done_o = 1'b0;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = 5'd19;
      quo_d = num_i;
      rem_d = '0;
      den_d = den_i;
    end else if (run_q) begin
      trial = {rem_q, quo_q[19]} - {2'b0, den_q};
      if (!trial[17]) begin
        rem_d = trial[16:0];
        quo_d = {quo_q[18:0], 1'b1};
      end else begin
        rem_d = {rem_q[15:0], quo_q[19]};
        quo_d = {quo_q[18:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd0) begin
        run_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  assign quo_o = quo_d;
  assign rem_o = rem_d[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end
endmodule
`default_nettype wire

### design/periodic_cell_list_neighbor_search_unit.sv
`default_nettype none
// Periodic cell-list neighbor search.
// A request is taken when start is high and busy is low: kind_i selects
// insert, query or clear and pos_*_i give the point. Results appear on the
// result ports for one cycle each, marked by valid_o; last_o flags the final
// result of a request. The receiver cannot stall, so results never wait.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i; the
// user must write it only while the block is idle, and the block itself does
// not enforce this. Requests are handled one at a time.
// Each insert or query computes the three cell indices with a shared serial
// divider. An insert needs three divisions, then a count read and, if the
// cell has room, the writes of the point and its new count; an out-of-range
// point is reported after the divisions, without the read or the writes.
// A query also wraps each index with a second division, then visits up to 27
// cells, reading each cell's count and then each stored point, which goes
// through a three-stage distance pipeline. Each hit is held until the next
// one or the end of the scan, so the final result carries last_o.
// After reset the count memory is swept to zero, one entry a cycle, over all
// 512 entries, while busy stays high. A clear repeats that sweep.
module periodic_cell_list_neighbor_search_unit import pcl_pkg::*; #(
  parameter int unsigned MAX_CELLS_PER_AXIS = MaxCellsPerAxis,
  parameter int unsigned CELL_CAPACITY      = CellCapacity,
  parameter int unsigned MAX_RESULTS        = MaxResults
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  kind_i,
  input  wire logic [15:0] pos_x_i,
  input  wire logic [15:0] pos_y_i,
  input  wire logic [15:0] pos_z_i,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  output logic             valid_o,
  output logic [2:0]       status_o,
  output logic [15:0]      near_x_o,
  output logic [15:0]      near_y_o,
  output logic [15:0]      near_z_o,
  output logic             last_o
);
  localparam int unsigned AW    = $clog2(MAX_CELLS_PER_AXIS) > 0 ?
                                  $clog2(MAX_CELLS_PER_AXIS) : 1;
  localparam int unsigned NCell = MAX_CELLS_PER_AXIS ** 3;
  localparam int unsigned CW    = 3 * AW;
  localparam int unsigned SW    = $clog2(CELL_CAPACITY) > 0 ? $clog2(CELL_CAPACITY) : 1;
  localparam int unsigned NW    = $clog2(CELL_CAPACITY + 1);
  localparam int unsigned RW    = $clog2(MAX_RESULTS + 1);
  localparam int unsigned NAW   = $clog2(MAX_CELLS_PER_AXIS + 1);

  typedef enum logic [3:0] {
    S_SWEEP, S_IDLE, S_DIV, S_DIVW, S_MOD, S_MODW, S_PREP, S_INS_RD, S_INS_WR,
    S_CELL, S_CNT, S_SCAN, S_DRAIN, S_DONE
  } state_e;

  state_e st_q;
  logic [15:0] box_q [3];
  logic [3:0]  cells_q [3];
  logic [31:0] cut_q;

  logic [1:0]  kind_q;
  logic [15:0] p_q [3];
  logic [19:0] raw_q [3];
  logic [AW-1:0] c_q [3];
  logic [1:0]  ax_q;
  logic [1:0]  o_q [3];
  logic [CW-1:0] cell_q;
  logic [SW-1:0] j_q;
  logic [NW-1:0] n_q;
  logic [RW-1:0] found_q;
  logic        hit_any_q;
  logic        trunc_q;
  logic [CW-1:0] sw_q;

  logic [NW-1:0] cnt_mem [NCell];
  logic [47:0]   pt_mem  [NCell*CELL_CAPACITY];
  logic [NW-1:0] cnt_rd_q;
  logic [47:0]   pt_rd_q;
  logic          cnt_we, pt_re;
  logic [CW-1:0] cnt_wa, cnt_ra;
  logic [NW-1:0] cnt_wd;
  logic [CW+SW-1:0] pt_a;

  logic        v1_q, v2_q, v3_q;
  logic [47:0] q1_q, q2_q;
  logic [17:0] d_q [3];
  logic [33:0] sq_q [3];
  logic        pend_q;
  logic [47:0] pend_pt_q;

  logic [NAW-1:0] ne [3];
  logic [15:0]    be [3];
  for (genvar a = 0; a < 3; a++) begin : g_eff
    always_comb begin
      if (cells_q[a] == 4'd0) ne[a] = NAW'(1);
      else if (32'(cells_q[a]) > MAX_CELLS_PER_AXIS) ne[a] = NAW'(MAX_CELLS_PER_AXIS);
      else ne[a] = NAW'(cells_q[a]);
      be[a] = (box_q[a] == 16'd0) ? 16'd1 : box_q[a];
    end
  end

  logic        div_start, div_done;
  logic [19:0] div_num, div_quo;
  logic [15:0] div_den, div_rem;
  always_comb begin
    if (st_q == S_MOD) begin
      div_num = raw_q[ax_q];
      div_den = 16'(ne[ax_q]);
    end else begin
      div_num = p_q[ax_q] * 20'(ne[ax_q]);
      div_den = be[ax_q];
    end
  end
  assign div_start = (st_q == S_DIV) || (st_q == S_MOD);
  pcl_div u_div (.clk_i, .rst_ni, .start_i(div_start), .num_i(div_num),
                 .den_i(div_den), .done_o(div_done), .quo_o(div_quo),
                 .rem_o(div_rem));

  // Neighbor cell of the current offsets.
  logic [AW-1:0] nb [3];
  logic          ax_on [3];
  for (genvar a = 0; a < 3; a++) begin : g_nb
    logic [NAW:0] s;
    always_comb begin
      s = (NAW+1)'(c_q[a]) + (NAW+1)'(ne[a]) + (NAW+1)'(o_q[a]) - (NAW+1)'(1);
      if (s >= (NAW+1)'(ne[a])) s = s - (NAW+1)'(ne[a]);
      if (s >= (NAW+1)'(ne[a])) s = s - (NAW+1)'(ne[a]);
      nb[a] = AW'(s);
      ax_on[a] = !((ne[a] == NAW'(1) && o_q[a] != 2'd1) ||
                   (ne[a] == NAW'(2) && o_q[a] == 2'd2));
    end
  end
  logic [CW-1:0] nb_cell;
  assign nb_cell = {nb[0], nb[1], nb[2]};

  // Insert cell with clamp and range check.
  logic [AW-1:0] ic [3];
  logic          bad;
  always_comb begin
    bad = 1'b0;
    for (int a = 0; a < 3; a++) begin
      ic[a] = AW'(raw_q[a]);
      if (raw_q[a] == 20'(ne[a])) ic[a] = AW'(ne[a] - NAW'(1));
      else if (raw_q[a] > 20'(ne[a])) bad = 1'b1;
    end
  end

  // Memory ports.
  always_comb begin
    cnt_we = 1'b0;
    cnt_wa = cell_q;
    cnt_wd = cnt_rd_q + NW'(1);
    cnt_ra = (st_q == S_CELL) ? nb_cell : cell_q;
    pt_re  = 1'b0;
    pt_a   = {cell_q, j_q};
    if (st_q == S_SWEEP) begin
      cnt_we = 1'b1;
      cnt_wa = sw_q;
      cnt_wd = '0;
    end else if (st_q == S_INS_WR && 32'(cnt_rd_q) < CELL_CAPACITY) begin
      cnt_we = 1'b1;
    end
    if (st_q == S_SCAN) pt_re = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    cnt_rd_q <= cnt_mem[cnt_ra];
    if (st_q == S_INS_WR && 32'(cnt_rd_q) < CELL_CAPACITY)
      pt_mem[{cell_q, SW'(cnt_rd_q)}] <= {p_q[0], p_q[1], p_q[2]};
    if (pt_re) pt_rd_q <= pt_mem[pt_a];
  end

  // Distance pipeline: delta, square, then sum and compare.
  logic [47:0] q0;
  logic [17:0] dd [3];
  logic [35:0] d2;
  logic        hit;
  always_comb begin
    q0 = pt_rd_q;
    for (int a = 0; a < 3; a++) begin
      dd[a] = {2'b0, p_q[a]} - {2'b0, q0[47-16*a -: 16]};
      if ($signed({dd[a], 1'b0}) < -$signed({3'b0, be[a]}))
        dd[a] = dd[a] + {2'b0, be[a]};
      else if ($signed({dd[a], 1'b0}) > $signed({3'b0, be[a]}))
        dd[a] = dd[a] - {2'b0, be[a]};
    end
    d2 = 36'(sq_q[0]) + 36'(sq_q[1]) + 36'(sq_q[2]);
    hit = v3_q && (d2 < 36'(cut_q));
  end

  always_ff @(posedge clk_i) begin
    q1_q <= q0;
    q2_q <= q1_q;
    for (int a = 0; a < 3; a++) begin
      d_q[a]  <= dd[a];
      sq_q[a] <= 34'($signed(d_q[a]) * $signed(d_q[a]));
    end
  end

  logic capped;
  assign capped = (32'(found_q) >= MAX_RESULTS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_SWEEP;
      sw_q <= '0;
      for (int a = 0; a < 3; a++) begin
        box_q[a] <= 16'hFFFF;
        cells_q[a] <= 4'd8;
      end
      cut_q <= '0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      pend_q <= 1'b0;
      valid_o <= 1'b0;
      status_o <= '0;
      near_x_o <= '0;
      near_y_o <= '0;
      near_z_o <= '0;
      last_o <= 1'b0;
      kind_q <= '0;
      ax_q <= '0;
      found_q <= '0;
      trunc_q <= 1'b0;
      hit_any_q <= 1'b0;
    end else begin
      valid_o <= 1'b0;
      v1_q <= pt_re;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_BOX_X:   box_q[0] <= cfg_data_i[15:0];
          REG_BOX_Y:   box_q[1] <= cfg_data_i[15:0];
          REG_BOX_Z:   box_q[2] <= cfg_data_i[15:0];
          REG_CELLS_X: cells_q[0] <= cfg_data_i[3:0];
          REG_CELLS_Y: cells_q[1] <= cfg_data_i[3:0];
          REG_CELLS_Z: cells_q[2] <= cfg_data_i[3:0];
          REG_CUTOFF:  cut_q <= cfg_data_i;
          default: ;
        endcase
      end
      // Results of the query pipeline: each hit is held until the next one so the
      // final one can carry the last flag.
      if (hit && !trunc_q) begin
        if (capped) begin
          trunc_q <= 1'b1;
        end else begin
          if (pend_q) begin
            valid_o <= 1'b1;
            status_o <= ST_NEIGHBOR;
            {near_x_o, near_y_o, near_z_o} <= pend_pt_q;
            last_o <= 1'b0;
          end
          pend_q <= 1'b1;
          pend_pt_q <= q2_q;
          found_q <= found_q + RW'(1);
          hit_any_q <= 1'b1;
        end
      end
      case (st_q)
        S_SWEEP: begin
          sw_q <= sw_q + CW'(1);
          if (32'(sw_q) == NCell - 1) st_q <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            kind_q <= kind_i;
            p_q[0] <= pos_x_i;
            p_q[1] <= pos_y_i;
            p_q[2] <= pos_z_i;
            ax_q <= '0;
            found_q <= '0;
            trunc_q <= 1'b0;
            hit_any_q <= 1'b0;
            pend_q <= 1'b0;
            if (kind_i == KIND_CLEAR) begin
              sw_q <= '0;
              valid_o <= 1'b1;
              status_o <= ST_CLEARED;
              {near_x_o, near_y_o, near_z_o} <= '0;
              last_o <= 1'b1;
              st_q <= S_SWEEP;
            end else if (kind_i == KIND_INSERT || kind_i == KIND_QUERY) begin
              st_q <= S_DIV;
            end
          end
        end
        S_DIV: st_q <= S_DIVW;
        S_DIVW: begin
          if (div_done) begin
            raw_q[ax_q] <= div_quo;
            if (kind_q == KIND_QUERY) st_q <= S_MOD;
            else if (ax_q == 2'd2) st_q <= S_PREP;
            else begin
              ax_q <= ax_q + 2'd1;
              st_q <= S_DIV;
            end
          end
        end
        S_MOD: st_q <= S_MODW;
        S_MODW: begin
          if (div_done) begin
            c_q[ax_q] <= AW'(div_rem);
            if (ax_q == 2'd2) st_q <= S_PREP;
            else begin
              ax_q <= ax_q + 2'd1;
              st_q <= S_DIV;
            end
          end
        end
        S_PREP: begin
          for (int a = 0; a < 3; a++) begin
            o_q[a] <= 2'd0;
          end
          if (kind_q == KIND_INSERT) begin
            if (bad) begin
              valid_o <= 1'b1;
              status_o <= ST_RANGE;
              {near_x_o, near_y_o, near_z_o} <= '0;
              last_o <= 1'b1;
              st_q <= S_IDLE;
            end else begin
              cell_q <= {ic[0], ic[1], ic[2]};
              st_q <= S_INS_RD;
            end
          end else begin
            st_q <= S_CELL;
          end
        end
        S_INS_RD: st_q <= S_INS_WR;
        S_INS_WR: begin
          valid_o <= 1'b1;
          status_o <= (32'(cnt_rd_q) < CELL_CAPACITY) ? ST_INSERTED : ST_FULL;
          {near_x_o, near_y_o, near_z_o} <= '0;
          last_o <= 1'b1;
          st_q <= S_IDLE;
        end
        S_CELL: begin
          if (trunc_q || (o_q[0] == 2'd3)) begin
            st_q <= S_DRAIN;
          end else begin
            if (o_q[2] == 2'd2) begin
              o_q[2] <= 2'd0;
              if (o_q[1] == 2'd2) begin
                o_q[1] <= 2'd0;
                o_q[0] <= o_q[0] + 2'd1;
              end else o_q[1] <= o_q[1] + 2'd1;
            end else o_q[2] <= o_q[2] + 2'd1;
            if (ax_on[0] && ax_on[1] && ax_on[2]) begin
              cell_q <= nb_cell;
              st_q <= S_CNT;
            end
          end
        end
        S_CNT: begin
          n_q <= cnt_rd_q;
          j_q <= '0;
          st_q <= (cnt_rd_q == '0) ? S_CELL : S_SCAN;
        end
        S_SCAN: begin
          j_q <= j_q + SW'(1);
          if (NW'(j_q) + NW'(1) >= n_q) st_q <= S_CELL;
        end
        S_DRAIN: begin
          if (!v1_q && !v2_q && !v3_q) st_q <= S_DONE;
        end
        S_DONE: begin
          valid_o <= 1'b1;
          last_o <= 1'b1;
          if (!hit_any_q) begin
            status_o <= ST_NONE;
            {near_x_o, near_y_o, near_z_o} <= '0;
          end else begin
            status_o <= trunc_q ? ST_TRUNCATED : ST_NEIGHBOR;
            {near_x_o, near_y_o, near_z_o} <= pend_pt_q;
          end
          pend_q <= 1'b0;
          st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assign busy = (st_q != S_IDLE);

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (st_q != S_IDLE || valid_o ||
      (kind_q != KIND_INSERT && kind_q != KIND_QUERY && kind_q != KIND_CLEAR)))
    else $error("request accepted without effect");
  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o && valid_o |=> !valid_o || $past(st_q) != S_DONE)
    else $error("result after final result");
  a_found_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(found_q) <= MAX_RESULTS)
    else $error("result count over cap");
  a_no_out_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_IDLE && !start) |=> !valid_o)
    else $error("result while idle");
`endif
endmodule
`default_nettype wire
